### rtl/core/yuvq_pkg.sv
package yuvq_pkg;

	// defaults for the top-level parameters
	localparam int ADDRESS_BITS_DEF      = 24;
	localparam int MAX_QUADS_PER_ROW_DEF = 1024;
	localparam int MAX_QUAD_ROWS         = 1024;

	// field and register widths
	localparam int LUMA_W      = 8;
	localparam int RGB_W       = 24;
	localparam int PIX_ADDR_W  = 24;
	localparam int ROW_W       = 10;
	localparam int QPR_W       = 11;
	localparam int ROWS_W      = 11;
	localparam int DIM_W       = 13;
	localparam int CFG_DATA_W  = 13;
	localparam int CFG_INDEX_W = 3;
	localparam int PIX_PER_QUAD = 4;

	// chroma arithmetic: Q16 products, offsets fit 10 bits signed
	localparam int PROD_W = 28;
	localparam int FRAC_W = 16;
	localparam int OFF_W  = 10;
	localparam int SUM_W  = 11;

	localparam logic signed [PROD_W-1:0] K_BLUE    = 132798;
	localparam logic signed [PROD_W-1:0] K_RED     = 104448;
	localparam logic signed [PROD_W-1:0] K_GREEN_B = 24759;
	localparam logic signed [PROD_W-1:0] K_GREEN_R = 53109;
	localparam logic [LUMA_W-1:0]        CHROMA_ZERO = 8'd128;
	localparam logic [LUMA_W-1:0]        CHAN_MAX    = 8'd255;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_QUADS_PER_ROW = 3'd0,
		REG_QUAD_ROWS     = 3'd1,
		REG_DEST_STRIDE   = 3'd2,
		REG_DEST_WIDTH    = 3'd3,
		REG_ROTATE        = 3'd4
	} reg_index_t;

	typedef struct packed {
		logic [QPR_W-1:0]  quads_per_row;
		logic [ROWS_W-1:0] quad_rows;
		logic [DIM_W-1:0]  dest_stride;
		logic [DIM_W-1:0]  dest_width;
		logic              rotate;
	} cfg_t;

	// one classified quad, ready for pixel expansion
	typedef struct packed {
		logic [PIX_PER_QUAD-1:0][LUMA_W-1:0]     luma;
		logic signed [OFF_W-1:0]                 off_r;
		logic signed [OFF_W-1:0]                 off_g;
		logic signed [OFF_W-1:0]                 off_b;
		logic [PIX_PER_QUAD-1:0][PIX_ADDR_W-1:0] addr;
		logic                                    last_frame;
	} quad_t;

endpackage

### rtl/core/yuvq_front.sv
module yuvq_front #(
	parameter int ADDRESS_BITS      = yuvq_pkg::ADDRESS_BITS_DEF,
	parameter int MAX_QUADS_PER_ROW = yuvq_pkg::MAX_QUADS_PER_ROW_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  yuvq_pkg::cfg_t                cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [yuvq_pkg::LUMA_W-1:0]   luma_top_left,
	input  logic [yuvq_pkg::LUMA_W-1:0]   luma_top_right,
	input  logic [yuvq_pkg::LUMA_W-1:0]   luma_bottom_left,
	input  logic [yuvq_pkg::LUMA_W-1:0]   luma_bottom_right,
	input  logic [yuvq_pkg::LUMA_W-1:0]   chroma_blue,
	input  logic [yuvq_pkg::LUMA_W-1:0]   chroma_red,
	output logic                          push,
	output yuvq_pkg::quad_t               push_data,
	input  logic                          full
);

	localparam int COL_W = $clog2(MAX_QUADS_PER_ROW);
	localparam int RS_W  = yuvq_pkg::ROW_W + yuvq_pkg::DIM_W;
	localparam int CS_W  = COL_W + yuvq_pkg::DIM_W;
	localparam int OUT_A = (ADDRESS_BITS < yuvq_pkg::PIX_ADDR_W) ?
		ADDRESS_BITS : yuvq_pkg::PIX_ADDR_W;
	localparam logic [yuvq_pkg::DIM_W-1:0]  MAX_QPR  =
		yuvq_pkg::DIM_W'(MAX_QUADS_PER_ROW);
	localparam logic [yuvq_pkg::ROWS_W-1:0] MAX_ROWS =
		yuvq_pkg::ROWS_W'(yuvq_pkg::MAX_QUAD_ROWS);
	localparam int FH = yuvq_pkg::FRAC_W + yuvq_pkg::OFF_W - 1;

	logic [COL_W-1:0]               col_q;
	logic [yuvq_pkg::ROW_W-1:0]     row_q;
	logic [yuvq_pkg::DIM_W-1:0]     qpr_c;
	logic [yuvq_pkg::ROWS_W-1:0]    rows_c;
	logic                           end_row;
	logic                           end_frame;
	logic                           accept;
	logic signed [8:0]              db;
	logic signed [8:0]              dr;

	logic                                                       valid_s1;
	logic [yuvq_pkg::PIX_PER_QUAD-1:0][yuvq_pkg::LUMA_W-1:0]    luma_s1;
	logic signed [yuvq_pkg::PROD_W-1:0]                         prod_b_s1;
	logic signed [yuvq_pkg::PROD_W-1:0]                         prod_r_s1;
	logic signed [yuvq_pkg::PROD_W-1:0]                         prod_gb_s1;
	logic signed [yuvq_pkg::PROD_W-1:0]                         prod_gr_s1;
	logic [RS_W-1:0]                                            rs_s1;
	logic [CS_W-1:0]                                            cs_s1;
	logic [COL_W-1:0]                                           col_s1;
	logic [yuvq_pkg::ROW_W-1:0]                                 row_s1;
	logic                                                       last_frame_s1;

	logic [ADDRESS_BITS-1:0] base;
	logic [ADDRESS_BITS-1:0] stride_a;
	logic [yuvq_pkg::PIX_PER_QUAD-1:0][ADDRESS_BITS-1:0] addr;

	// handshake: stage 1 drains into the queue when it has room
	assign in_ready = !valid_s1 || !full;
	assign accept   = in_valid && in_ready;
	assign push     = valid_s1 && !full;

	// size clamping and end-of-row / end-of-frame
	always_comb begin
		qpr_c = yuvq_pkg::DIM_W'(cfg.quads_per_row);
		if (cfg.quads_per_row == '0)
			qpr_c = yuvq_pkg::DIM_W'(1);
		else if (yuvq_pkg::DIM_W'(cfg.quads_per_row) > MAX_QPR)
			qpr_c = MAX_QPR;
		rows_c = cfg.quad_rows;
		if (cfg.quad_rows == '0)
			rows_c = yuvq_pkg::ROWS_W'(1);
		else if (cfg.quad_rows > MAX_ROWS)
			rows_c = MAX_ROWS;
		end_row   = (yuvq_pkg::DIM_W'(col_q) + yuvq_pkg::DIM_W'(1)) >= qpr_c;
		end_frame = end_row &&
			((yuvq_pkg::ROWS_W'(row_q) + yuvq_pkg::ROWS_W'(1)) >= rows_c);
	end

	// chroma around zero
	assign db = $signed({1'b0, chroma_blue}) - $signed({1'b0, yuvq_pkg::CHROMA_ZERO});
	assign dr = $signed({1'b0, chroma_red}) - $signed({1'b0, yuvq_pkg::CHROMA_ZERO});

	// quad position walks the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (end_row) begin
				col_q <= '0;
				row_q <= end_frame ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	// stage 1: chroma and address products
	always_ff @(posedge clk) begin
		if (accept) begin
			luma_s1[0]    <= luma_top_left;
			luma_s1[1]    <= luma_top_right;
			luma_s1[2]    <= luma_bottom_left;
			luma_s1[3]    <= luma_bottom_right;
			prod_b_s1     <= yuvq_pkg::PROD_W'(db) * yuvq_pkg::K_BLUE;
			prod_r_s1     <= yuvq_pkg::PROD_W'(dr) * yuvq_pkg::K_RED;
			prod_gb_s1    <= yuvq_pkg::PROD_W'(db) * yuvq_pkg::K_GREEN_B;
			prod_gr_s1    <= yuvq_pkg::PROD_W'(dr) * yuvq_pkg::K_GREEN_R;
			rs_s1         <= RS_W'(row_q) * RS_W'(cfg.dest_stride);
			cs_s1         <= CS_W'(col_q) * CS_W'(cfg.dest_stride);
			col_s1        <= col_q;
			row_s1        <= row_q;
			last_frame_s1 <= end_frame;
		end
	end

	// destination addresses of the four pixels
	always_comb begin
		stride_a = ADDRESS_BITS'(cfg.dest_stride);
		if (cfg.rotate) begin
			base = ADDRESS_BITS'(cfg.dest_width) - ADDRESS_BITS'(1)
				- (ADDRESS_BITS'(row_s1) << 1) + (ADDRESS_BITS'(cs_s1) << 1);
			addr[0] = base;
			addr[1] = base + stride_a;
			addr[2] = base - ADDRESS_BITS'(1);
			addr[3] = base + stride_a - ADDRESS_BITS'(1);
		end else begin
			base = (ADDRESS_BITS'(rs_s1) << 1) + (ADDRESS_BITS'(col_s1) << 1);
			addr[0] = base;
			addr[1] = base + ADDRESS_BITS'(1);
			addr[2] = base + stride_a;
			addr[3] = base + stride_a + ADDRESS_BITS'(1);
		end
	end

	// offset = product >>> 16 (floor); off_g is minus both
	always_comb begin
		push_data.luma  = luma_s1;
		push_data.off_b = prod_b_s1[FH:yuvq_pkg::FRAC_W];
		push_data.off_r = prod_r_s1[FH:yuvq_pkg::FRAC_W];
		push_data.off_g = yuvq_pkg::OFF_W'(0) - prod_gb_s1[FH:yuvq_pkg::FRAC_W]
			- prod_gr_s1[FH:yuvq_pkg::FRAC_W];
		for (int k = 0; k < yuvq_pkg::PIX_PER_QUAD; k++)
			push_data.addr[k] = yuvq_pkg::PIX_ADDR_W'(addr[k][OUT_A-1:0]);
		push_data.last_frame = last_frame_s1;
	end

endmodule

### rtl/core/yuvq_queue.sv
module yuvq_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  yuvq_pkg::quad_t push_data,
	output logic            full,
	input  logic            pop,
	output yuvq_pkg::quad_t head,
	output logic            not_empty
);

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	yuvq_pkg::quad_t  entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = count_q == CNT_W'(DEPTH);
	assign not_empty = count_q != '0;
	assign head      = entry_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

endmodule

### rtl/core/yuvq_back.sv
module yuvq_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  yuvq_pkg::quad_t                  head,
	input  logic                             not_empty,
	output logic                             pop,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [yuvq_pkg::RGB_W-1:0]       pixel_rgb,
	output logic [yuvq_pkg::PIX_ADDR_W-1:0]  dest_address,
	output logic                             last_of_quad,
	output logic                             last_of_frame
);

	localparam int K_W = $clog2(yuvq_pkg::PIX_PER_QUAD);
	localparam logic [K_W-1:0] K_LAST = K_W'(yuvq_pkg::PIX_PER_QUAD - 1);

	logic [K_W-1:0]                         k_q;
	logic                                   load;
	logic [yuvq_pkg::LUMA_W-1:0]            y;
	logic [yuvq_pkg::RGB_W-1:0]             rgb;
	logic                                   out_valid_q;
	logic [yuvq_pkg::RGB_W-1:0]             pixel_q;
	logic [yuvq_pkg::PIX_ADDR_W-1:0]        addr_q;
	logic                                   loq_q;
	logic                                   lof_q;

	// luma plus offset, saturated to one byte
	function automatic logic [yuvq_pkg::LUMA_W-1:0] sat_chan(
		input logic [yuvq_pkg::LUMA_W-1:0] luma,
		input logic signed [yuvq_pkg::OFF_W-1:0] off
	);
		logic signed [yuvq_pkg::SUM_W-1:0] sum;
		sum = $signed(yuvq_pkg::SUM_W'(luma)) + yuvq_pkg::SUM_W'(off);
		if (sum < 0)
			return '0;
		else if (sum > $signed(yuvq_pkg::SUM_W'(yuvq_pkg::CHAN_MAX)))
			return yuvq_pkg::CHAN_MAX;
		else
			return sum[yuvq_pkg::LUMA_W-1:0];
	endfunction

	assign load = not_empty && (!out_valid_q || out_ready);
	assign pop  = load && (k_q == K_LAST);

	assign y   = head.luma[k_q];
	assign rgb = {sat_chan(y, head.off_r), sat_chan(y, head.off_g), sat_chan(y, head.off_b)};

	// pixel index within the head quad, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				k_q <= k_q + 1'b1;
			if (load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (load) begin
			pixel_q <= rgb;
			addr_q  <= head.addr[k_q];
			loq_q   <= k_q == K_LAST;
			lof_q   <= (k_q == K_LAST) && head.last_frame;
		end
	end

	assign out_valid     = out_valid_q;
	assign pixel_rgb     = pixel_q;
	assign dest_address  = addr_q;
	assign last_of_quad  = loq_q;
	assign last_of_frame = lof_q;

endmodule

### rtl/core/yuv420_quad_to_rgb32_rotate.sv
// Path: an accepted quad is registered in stage 1, pushed into the quad queue
// and then expanded pixel by pixel in the output register.
// Throughput: one pixel per cycle while out_ready is high and a quad waits,
// set by the one-pixel output register; a 2-quad queue lets input run ahead.
// Reset (arst_n low, asynchronous): queue and outputs empty, quad position at
// the frame origin, registers at 1/1/1/1 with rotation off.
module yuv420_quad_to_rgb32_rotate #(
	parameter int ADDRESS_BITS      = yuvq_pkg::ADDRESS_BITS_DEF,
	parameter int MAX_QUADS_PER_ROW = yuvq_pkg::MAX_QUADS_PER_ROW_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [yuvq_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [yuvq_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [yuvq_pkg::LUMA_W-1:0]         luma_top_left,
	input  logic [yuvq_pkg::LUMA_W-1:0]         luma_top_right,
	input  logic [yuvq_pkg::LUMA_W-1:0]         luma_bottom_left,
	input  logic [yuvq_pkg::LUMA_W-1:0]         luma_bottom_right,
	input  logic [yuvq_pkg::LUMA_W-1:0]         chroma_blue,
	input  logic [yuvq_pkg::LUMA_W-1:0]         chroma_red,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [yuvq_pkg::RGB_W-1:0]          pixel_rgb,
	output logic [yuvq_pkg::PIX_ADDR_W-1:0]     dest_address,
	output logic                                last_of_quad,
	output logic                                last_of_frame
);

	yuvq_pkg::cfg_t  cfg_q;
	logic            push;
	yuvq_pkg::quad_t push_data;
	logic            full;
	logic            pop;
	yuvq_pkg::quad_t head;
	logic            not_empty;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.quads_per_row <= yuvq_pkg::QPR_W'(1);
			cfg_q.quad_rows     <= yuvq_pkg::ROWS_W'(1);
			cfg_q.dest_stride   <= yuvq_pkg::DIM_W'(1);
			cfg_q.dest_width    <= yuvq_pkg::DIM_W'(1);
			cfg_q.rotate        <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				yuvq_pkg::REG_QUADS_PER_ROW: begin
					cfg_q.quads_per_row <= cfg_data[yuvq_pkg::QPR_W-1:0];
				end
				yuvq_pkg::REG_QUAD_ROWS: begin
					cfg_q.quad_rows <= cfg_data[yuvq_pkg::ROWS_W-1:0];
				end
				yuvq_pkg::REG_DEST_STRIDE: begin
					cfg_q.dest_stride <= cfg_data[yuvq_pkg::DIM_W-1:0];
				end
				yuvq_pkg::REG_DEST_WIDTH: begin
					cfg_q.dest_width <= cfg_data[yuvq_pkg::DIM_W-1:0];
				end
				yuvq_pkg::REG_ROTATE: begin
					cfg_q.rotate <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	yuvq_front #(
		.ADDRESS_BITS      (ADDRESS_BITS),
		.MAX_QUADS_PER_ROW (MAX_QUADS_PER_ROW)
	) u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg_q),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.luma_top_left     (luma_top_left),
		.luma_top_right    (luma_top_right),
		.luma_bottom_left  (luma_bottom_left),
		.luma_bottom_right (luma_bottom_right),
		.chroma_blue       (chroma_blue),
		.chroma_red        (chroma_red),
		.push              (push),
		.push_data         (push_data),
		.full              (full)
	);

	yuvq_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty)
	);

	yuvq_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.not_empty     (not_empty),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pixel_rgb     (pixel_rgb),
		.dest_address  (dest_address),
		.last_of_quad  (last_of_quad),
		.last_of_frame (last_of_frame)
	);

endmodule

### rtl/core/yuvq_checker.sv
module yuvq_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic [yuvq_pkg::RGB_W-1:0]         pixel_rgb,
	input logic [yuvq_pkg::PIX_ADDR_W-1:0]    dest_address,
	input logic                               last_of_quad,
	input logic                               last_of_frame
);

	logic [1:0] pix_cnt_q;
	logic [2:0] pending_q;
	logic       in_acc;
	logic       out_acc;
	logic       quad_done;

	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid && out_ready;
	assign quad_done = out_acc && last_of_quad;

	// pixels delivered within the current quad, quads in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_cnt_q <= '0;
			pending_q <= '0;
		end else begin
			if (out_acc)
				pix_cnt_q <= pix_cnt_q + 1'b1;
			if (in_acc && !quad_done)
				pending_q <= pending_q + 1'b1;
			else if (quad_done && !in_acc)
				pending_q <= pending_q - 1'b1;
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_rgb)
			&& $stable(dest_address) && $stable(last_of_quad) && $stable(last_of_frame))
		else $error("output item changed while stalled");

	a_frame_in_quad: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_of_frame |-> last_of_quad)
		else $error("frame end flagged off a quad boundary");

	a_fourth_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_of_quad == (pix_cnt_q == 2'd3)))
		else $error("quad end not on the fourth pixel");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 3'd0)
		else $error("pixel without an accepted quad");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd4)
		else $error("too many quads in flight");

endmodule

bind yuv420_quad_to_rgb32_rotate yuvq_checker u_checker (.*);
